/* rtl/b64d_pkg.sv */
package b64d_pkg;

    // One decoded group handed from the front end to the byte serializer
    typedef struct packed {
        logic [23:0] word;       // three bytes, first byte in the top bits
        logic [1:0]  count;      // bytes to emit, 1..3
        logic        eom;        // mark the final emitted byte as last
    } group_t;

endpackage

/* rtl/base64_stream_decoder.sv */
// Channel   Direction  tdata             tlast           Meaning
// s_axis    in         [7:0] char_in     end_of_message  one encoded character
// m_axis    out        [7:0] data_byte   last            one decoded byte
//
// Input takes one character per cycle while the group queue has room.
// Each complete group yields up to three bytes, one per cycle from the serializer
// while the output is ready; each group goes via a queue slot into group_reg.
// Output stalls back up through the group queue before the input stalls.
// rst_n clears phase, accumulator, queue and serializer at once.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast    // last
);
    import b64d_pkg::*;

    logic   push_valid, push_ready;
    logic   pop_valid, pop_ready;
    group_t push_data, pop_data;

    b64d_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/b64d_front.sv */
module b64d_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] char_in
    input  logic             s_axis_tlast,   // end_of_message
    output logic             push_valid,
    input  logic             push_ready,
    output b64d_pkg::group_t push_data
);
    import b64d_pkg::*;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] OFS_UPPER    = 8'd65;
    localparam logic [7:0] OFS_LOWER    = 8'd71;
    localparam logic [7:0] OFS_DIGIT    = 8'd4;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [1:0] PHASE_LAST   = 2'd3;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= "A" && c <= "Z")
            begin
                v = c - OFS_UPPER;
            end
            else if (c >= "a" && c <= "z")
            begin
                v = c - OFS_LOWER;
            end
            else if (c >= "0" && c <= "9")
            begin
                v = c + OFS_DIGIT;
            end
            else if (c == CHAR_PLUS)
            begin
                v = {2'b00, SEXTET_PLUS};
            end
            else if (c == CHAR_SLASH)
            begin
                v = {2'b00, SEXTET_SLASH};
            end
            return v[5:0];
        end
    endfunction

    logic [1:0]  phase_reg, phase_next;
    logic [17:0] acc_reg, acc_next;
    logic        third_pad_reg, third_pad_next;

    logic        xfer;
    logic        is_newline;
    logic        is_pad;
    logic [5:0]  sextet;
    logic [1:0]  trim_count;

    assign s_axis_tready = push_ready;
    assign xfer          = s_axis_tvalid & s_axis_tready;
    assign is_newline    = (s_axis_tdata == CHAR_NEWLINE);
    assign is_pad        = (s_axis_tdata == CHAR_PAD);
    assign sextet        = sextet_of(s_axis_tdata);

    // Each pad in positions three and four trims one byte, only on the end mark
    always_comb
    begin
        trim_count = 2'd3;
        if (s_axis_tlast)
        begin
            trim_count = 2'd3 - {1'b0, third_pad_reg} - {1'b0, is_pad};
        end
    end

    assign push_valid      = xfer & ~is_newline & (phase_reg == PHASE_LAST);
    assign push_data.word  = {acc_reg, sextet};
    assign push_data.count = trim_count;
    assign push_data.eom   = s_axis_tlast;

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        third_pad_next = third_pad_reg;
        if (xfer)
        begin
            if (is_newline)
            begin
                if (s_axis_tlast)
                begin
                    phase_next     = 2'd0;
                    acc_next       = 18'd0;
                    third_pad_next = 1'b0;
                end
            end
            else if (phase_reg != PHASE_LAST && !s_axis_tlast)
            begin
                acc_next   = {acc_reg[11:0], sextet};
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd0)
                begin
                    third_pad_next = 1'b0;
                end
                else if (phase_reg == 2'd2)
                begin
                    third_pad_next = is_pad;
                end
            end
            else
            begin
                // group complete, or partial group dropped at the end mark
                phase_next     = 2'd0;
                acc_next       = 18'd0;
                third_pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            acc_reg       <= 18'd0;
            third_pad_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
        end
    end

endmodule

/* rtl/b64d_queue.sv */
module b64d_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  b64d_pkg::group_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output b64d_pkg::group_t pop_data
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    group_t          slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/b64d_back.sv */
module b64d_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  b64d_pkg::group_t pop_data,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tlast    // last
);
    import b64d_pkg::*;

    group_t     group_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       xfer;
    logic       final_byte;

    assign m_axis_tvalid = busy_reg;
    assign xfer          = busy_reg & m_axis_tready;
    assign final_byte    = (idx_reg == group_reg.count - 2'd1);
    // take the next group when idle or as the current one finishes
    assign pop_ready     = ~busy_reg | (xfer & final_byte);

    always_comb
    begin
        case (idx_reg)
            2'd0:    m_axis_tdata = group_reg.word[23:16];
            2'd1:    m_axis_tdata = group_reg.word[15:8];
            default: m_axis_tdata = group_reg.word[7:0];
        endcase
    end

    assign m_axis_tlast = group_reg.eom & final_byte;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop_ready)
        begin
            busy_next = pop_valid;
            idx_next  = 2'd0;
        end
        else if (xfer)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            group_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

/* tb/sv/b64_decode_checker.sv */
module b64_decode_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tlast,   // end_of_message
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] data_byte
    input  logic       m_axis_tlast,   // last
    output int         mismatches,
    output int         bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] NEWLINE  = 8'h0A;
    localparam logic [7:0] PAD_CHAR = "=";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } decoded_byte_t;

    decoded_byte_t expected_bytes[$];

    // Decoder state as the block should hold it
    logic [1:0]  group_pos  = '0;
    logic [17:0] sextet_acc = '0;
    logic        third_pad  = 1'b0;

    int mismatch_count = 0;
    int pending_count  = 0;

    assign mismatches    = mismatch_count;
    assign bytes_pending = pending_count;

    task automatic report_mismatch(input string what, input logic [7:0] got_byte,
                                   input logic got_last, input decoded_byte_t want);
        $display("%0t ns: %s: got byte %02h last %0b, expected byte %02h last %0b",
                 $time, what, got_byte, got_last, want.data_byte, want.last);
        mismatch_count++;
    endtask

    function automatic logic [5:0] sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return 6'(c - 8'd65);
        if (c >= "a" && c <= "z")
            return 6'(c - 8'd71);
        if (c >= "0" && c <= "9")
            return 6'(c + 8'd4);
        if (c == "+")
            return 6'd62;
        if (c == "/")
            return 6'd63;
        return 6'd0;
    endfunction

    task automatic clear_group();
        group_pos  = '0;
        sextet_acc = '0;
        third_pad  = 1'b0;
    endtask

    // Advance the group state by one character and queue the bytes it releases
    task automatic decode_char(input logic [7:0] c, input logic eom);
        logic [5:0]    sx;
        logic [23:0]   word;
        logic          is_pad;
        int            nbytes;
        decoded_byte_t item;
        if (c == NEWLINE)
        begin
            if (eom)
                clear_group();
            return;
        end
        sx     = sextet_value(c);
        is_pad = (c == PAD_CHAR);
        if (group_pos != 2'd3)
        begin
            if (group_pos == 2'd0)
                third_pad = 1'b0;
            if (group_pos == 2'd2)
                third_pad = is_pad;
            sextet_acc = {sextet_acc[11:0], sx};
            if (eom)
                clear_group();
            else
                group_pos = group_pos + 2'd1;
            return;
        end
        word   = {sextet_acc, sx};
        nbytes = 3;
        if (eom)
        begin
            if (third_pad)
                nbytes--;
            if (is_pad)
                nbytes--;
        end
        for (int i = 0; i < nbytes; i++)
        begin
            item.data_byte = word[23 - 8 * i -: 8];
            item.last      = eom && (i == nbytes - 1);
            expected_bytes.push_back(item);
        end
        clear_group();
    endtask

    always @(posedge clk)
    begin
        decoded_byte_t want;
        if (rst_n)
        begin
            // Check the output before predicting: a byte never leaves in its own cycle
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    want = '0;
                    report_mismatch("unexpected byte", m_axis_tdata, m_axis_tlast, want);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data_byte)
                        report_mismatch("data_byte mismatch", m_axis_tdata, m_axis_tlast, want);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last mismatch", m_axis_tdata, m_axis_tlast, want);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_char(s_axis_tdata, s_axis_tlast);
            pending_count = expected_bytes.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] PAD_CHAR   = "=";
    localparam int         ITEM_COUNT = 280;   // characters; about 310 transfers with newlines
    localparam int         QUIET_FROM = 240;
    localparam int         HOLD_AT    = 120;
    localparam int         HOLD_LEN   = 80;
    localparam int         STALL_LIMIT = 1000;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int mismatches;
    int bytes_pending;
    int chars_sent    = 0;
    int stall_cycles  = 0;
    bit quiet         = 1'b0;
    bit hold_request  = 1'b0;
    bit hold_served   = 1'b0;

    always #1 clk = ~clk;

    base64_stream_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    b64_decode_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .bytes_pending (bytes_pending)
    );

    // Offer one character and hold it until the transfer
    task automatic send_char(input logic [7:0] c, input logic eom);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eom;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (c != NEWLINE)
            chars_sent++;
        if (chars_sent >= QUIET_FROM)
            quiet = 1'b1;
        if (chars_sent >= HOLD_AT)
            hold_request = 1'b1;
    endtask

    task automatic send_text(input string s, input bit eom_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eom_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] random_b64_char();
        int v;
        v = $urandom_range(0, 63);
        if (v < 26)
            return 8'("A" + v);
        if (v < 52)
            return 8'("a" + v - 26);
        if (v < 62)
            return 8'("0" + v - 52);
        if (v == 62)
            return "+";
        return "/";
    endfunction

    // One encoded message: whole groups, optional padding, now and then cut short
    task automatic send_message();
        int         ngroups;
        int         pad_kind;
        int         cut_at;
        logic [7:0] c;
        ngroups  = $urandom_range(1, 3);
        pad_kind = $urandom_range(0, 3);
        cut_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 3;
        for (int g = 0; g < ngroups; g++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_char(NEWLINE, 1'b0);
                c = random_b64_char();
                if (g == ngroups - 1)
                begin
                    if (p == 3 && (pad_kind == 1 || pad_kind == 2))
                        c = PAD_CHAR;
                    if (p == 2 && (pad_kind == 2 || pad_kind == 3))
                        c = PAD_CHAR;
                    if (p == cut_at)
                    begin
                        send_char(c, 1'b1);
                        return;
                    end
                end
                send_char(c, 1'b0);
            end
        end
    endtask

    // Receiver: short random stalls, one long hold-off on request
    always
    begin
        @(posedge clk);
        if (hold_request && !hold_served)
        begin
            m_axis_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clk);
            hold_served = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("base64_stream_decoder test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("TWFu", 1'b0);
        send_text("+/9", 1'b0);
        send_char(8'hFF, 1'b0);          // unknown character in the fourth slot
        send_char(8'h00, 1'b0);
        send_text("=Z=", 1'b0);          // padding without end mark is plain zero
        send_text("az=Z", 1'b1);         // pad in third slot only trims one byte
        send_text("AA==", 1'b1);
        send_text("AAAA", 1'b1);         // real 'A' must not be trimmed
        send_text("AB=", 1'b1);          // partial group dropped
        send_text("0\n", 1'b0);
        send_char(NEWLINE, 1'b1);        // newline with end mark clears the group

        while (chars_sent < ITEM_COUNT)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                send_char(NEWLINE, 1'b1);    // realign to a group boundary
            end
            else
            begin
                send_message();
            end
        end
        s_axis_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (bytes_pending != 0);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("base64_stream_decoder test passed");
        else
            $display("base64_stream_decoder test failed");
        $finish;
    end

endmodule
